// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the serial ring buffer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define SRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define SRB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srb_pkg.sv =====
// Package: action codes, request and result payloads, and pending-stage status.
`timescale 1ns / 1ps

package srb_pkg;

  localparam int unsigned LVL_W = 4;

  typedef enum logic [2:0] {
    ACT_FLUSH_RX = 3'd0,
    ACT_FLUSH_TX = 3'd1,
    ACT_TX_PUT   = 3'd2,
    ACT_TX_DRAIN = 3'd3,
    ACT_RX_BYTE  = 3'd4,
    ACT_RX_GET   = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             data_valid;
    logic             put_accepted;
    logic             tx_int_enabled;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
  } out_item_t;

  typedef struct packed {
    logic             rx_sel;
    logic             data_valid;
    logic             put_accepted;
    logic             tx_int_enabled;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
  } pend_t;

endpackage

// ===== rtl/srb_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface srb_in_if;
  import srb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srb_out_if;
  import srb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/srb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/serial_tx_rx_ring_buffers_top.sv =====
// Top level: transmit and receive byte ring buffers of a serial port.
//
// Requests arrive on in_if (valid/ready): an action code and a byte. Each
// request yields exactly one result on out_if: the byte sent or delivered,
// its valid flag, the put-accepted flag, the transmit interrupt enable and
// both buffer levels after the request.
// Indices, levels and the interrupt enable are updated in the cycle the
// request is taken; the store read is issued in that cycle too, and the
// result is assembled from the registered RAM data as the pending stage
// loads the output register. Throughput: one request per cycle while
// out_if takes results, set by the single read port per store.
// A pending stage and an output register sit between the two sides, so a
// new request is taken while one result waits to be collected.
// When out_if stalls, the pending stage fills and in_if.ready drops until
// the output register is freed.
// Reset (rst_n, synchronous) clears indices, levels, the interrupt enable
// and both valid flags; stored bytes are left undefined and are never read
// before being written.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module serial_tx_rx_ring_buffers_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  srb_in_if.sink           in_if,
  srb_out_if.source        out_if
);

  import srb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL_LVL = FW'(DEPTH);

  logic [AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [FW-1:0] tx_fill_r, tx_fill_nxt, rx_fill_r, rx_fill_nxt;
  logic          tx_irq_r, tx_irq_nxt;

  logic          pend_r, pend_nxt;
  pend_t         pend_info_r, pend_info_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          load_out, in_ready, acc;
  logic          tx_we, rx_we, tx_re, rx_re;
  logic          res_valid, res_put;
  logic [7:0]    tx_rd, rx_rd;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  assign load_out = !out_valid_r || out_if.ready;
  assign in_ready = !pend_r || load_out;
  assign acc      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_fill_nxt = tx_fill_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    rx_fill_nxt = rx_fill_r;
    tx_irq_nxt  = tx_irq_r;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_re       = 1'b0;
    res_valid   = 1'b0;
    res_put     = 1'b0;
    if (acc) begin
      case (action_t'(in_if.data.action))
        ACT_FLUSH_RX: begin
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
          rx_fill_nxt = '0;
        end
        ACT_FLUSH_TX: begin
          tx_head_nxt = '0;
          tx_tail_nxt = '0;
          tx_fill_nxt = '0;
        end
        ACT_TX_PUT: begin
          if (tx_fill_r != FULL_LVL) begin
            tx_we       = 1'b1;
            tx_tail_nxt = next_idx(tx_tail_r);
            tx_fill_nxt = tx_fill_r + FW'(1);
            res_put     = 1'b1;
          end
          tx_irq_nxt = 1'b1;
        end
        ACT_TX_DRAIN: begin
          if (tx_fill_r != '0) begin
            tx_re       = 1'b1;
            tx_head_nxt = next_idx(tx_head_r);
            tx_fill_nxt = tx_fill_r - FW'(1);
            res_valid   = 1'b1;
          end
          if (tx_fill_nxt == '0) begin
            tx_irq_nxt = 1'b0;
          end
        end
        ACT_RX_BYTE: begin
          rx_we       = 1'b1;
          rx_tail_nxt = next_idx(rx_tail_r);
          if (rx_fill_r != FULL_LVL) begin
            rx_fill_nxt = rx_fill_r + FW'(1);
          end else begin
            rx_head_nxt = next_idx(rx_head_r);
          end
        end
        ACT_RX_GET: begin
          if (rx_fill_r != '0) begin
            rx_re       = 1'b1;
            rx_head_nxt = next_idx(rx_head_r);
            rx_fill_nxt = rx_fill_r - FW'(1);
            res_valid   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    pend_info_nxt = pend_info_r;
    if (acc) begin
      pend_nxt                     = 1'b1;
      pend_info_nxt.rx_sel         = (in_if.data.action == ACT_RX_GET);
      pend_info_nxt.data_valid     = res_valid;
      pend_info_nxt.put_accepted   = res_put;
      pend_info_nxt.tx_int_enabled = tx_irq_nxt;
      pend_info_nxt.tx_level       = LVL_W'(tx_fill_nxt);
      pend_info_nxt.rx_level       = LVL_W'(rx_fill_nxt);
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (pend_r && load_out) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.data_out       = !pend_info_r.data_valid ? 8'd0 :
                                    (pend_info_r.rx_sel ? rx_rd : tx_rd);
      out_item_nxt.data_valid     = pend_info_r.data_valid;
      out_item_nxt.put_accepted   = pend_info_r.put_accepted;
      out_item_nxt.tx_int_enabled = pend_info_r.tx_int_enabled;
      out_item_nxt.tx_level       = pend_info_r.tx_level;
      out_item_nxt.rx_level       = pend_info_r.rx_level;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_fill_r   <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_fill_r   <= '0;
      tx_irq_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_fill_r   <= tx_fill_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_irq_r    <= tx_irq_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_info_r <= pend_info_nxt;
    out_item_r  <= out_item_nxt;
  end

  srb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_tail_r),
    .wr_data (in_if.data.data_in),
    .rd_en   (tx_re),
    .rd_addr (tx_head_r),
    .rd_data (tx_rd)
  );

  srb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_tail_r),
    .wr_data (in_if.data.data_in),
    .rd_en   (rx_re),
    .rd_addr (rx_head_r),
    .rd_data (rx_rd)
  );

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  `SRB_ASSERT_IMP(a_tx_fill_bound, 1'b1, tx_fill_r <= FULL_LVL, "tx level above depth")
  `SRB_ASSERT_IMP(a_tx_empty_idx, tx_fill_r == '0, tx_head_r == tx_tail_r,
                  "tx empty with head and tail apart")
  `SRB_ASSERT_NXT(a_acc_pend, acc, pend_r, "taken request not held in pending stage")
  `SRB_ASSERT_NXT(a_pend_hold, pend_r && !load_out, pend_r && $stable(pend_info_r),
                  "pending result lost under stall")

endmodule
